@@ rtl/core/orfb_pkg.sv @@
// Shared constants and types for the oriented rectangle fill and blend block.
`timescale 1ns / 1ps

package orfb_pkg;

  localparam int FRAC_BITS = 8;
  localparam int PIX_BITS  = 12;
  localparam int CFG_W     = 24;
  localparam int COLOR_W   = 32;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = COLOR_W / CHAN_W;
  localparam int BLEND_W   = 2 * CHAN_W;
  localparam int IDX_W     = 3;

  localparam int FIX_W  = PIX_BITS + FRAC_BITS;
  localparam int D_W    = ((FIX_W > CFG_W) ? FIX_W : CFG_W) + 1;
  localparam int PROD_W = CFG_W + D_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DETP_W = 2 * CFG_W;
  localparam int DET_W  = DETP_W + 1;

  localparam int IN_W  = 2 * PIX_BITS + COLOR_W;
  localparam int TDATA_IN_W  = ((IN_W + 7) / 8) * 8;
  localparam int TDATA_OUT_W = ((COLOR_W + 7) / 8) * 8;

  typedef enum logic [IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_EDGE_A_X = 3'd2,
    REG_EDGE_A_Y = 3'd3,
    REG_EDGE_B_X = 3'd4,
    REG_EDGE_B_Y = 3'd5,
    REG_FILL_COLOR = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] ox;
    logic signed [CFG_W-1:0] oy;
    logic signed [CFG_W-1:0] ea_x;
    logic signed [CFG_W-1:0] ea_y;
    logic signed [CFG_W-1:0] eb_x;
    logic signed [CFG_W-1:0] eb_y;
  } geom_cfg_t;

  typedef struct packed {
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

@@ rtl/core/orfb_geom.sv @@
// Parallelogram coverage test by cross products against the determinant.
`timescale 1ns / 1ps

module orfb_geom (
  input  logic                          clk,
  input  orfb_pkg::pipe_en_t            en,
  input  logic [orfb_pkg::PIX_BITS-1:0] px,
  input  logic [orfb_pkg::PIX_BITS-1:0] py,
  input  orfb_pkg::geom_cfg_t           cfg,
  output logic                          in_rect
);

  localparam int D_W    = orfb_pkg::D_W;
  localparam int PROD_W = orfb_pkg::PROD_W;
  localparam int NUM_W  = orfb_pkg::NUM_W;
  localparam int DETP_W = orfb_pkg::DETP_W;
  localparam int DET_W  = orfb_pkg::DET_W;
  localparam int PAD_W  = D_W - orfb_pkg::FIX_W;

  logic signed [D_W-1:0]    dx;
  logic signed [D_W-1:0]    dy;
  logic signed [PROD_W-1:0] p_bydx;
  logic signed [PROD_W-1:0] p_bxdy;
  logic signed [PROD_W-1:0] p_axdy;
  logic signed [PROD_W-1:0] p_aydx;
  logic signed [NUM_W-1:0]  nu;
  logic signed [NUM_W-1:0]  nv;
  logic signed [DETP_W-1:0] dp0;
  logic signed [DETP_W-1:0] dp1;
  logic signed [DET_W-1:0]  det;
  logic signed [NUM_W-1:0]  det_ext;
  logic                     u_ok;
  logic                     v_ok;

  assign dx = $signed({{PAD_W{1'b0}}, px, {orfb_pkg::FRAC_BITS{1'b0}}}) - D_W'(cfg.ox);
  assign dy = $signed({{PAD_W{1'b0}}, py, {orfb_pkg::FRAC_BITS{1'b0}}}) - D_W'(cfg.oy);

  always_ff @(posedge clk) begin
    dp0 <= DETP_W'(cfg.ea_x) * DETP_W'(cfg.eb_y);
    dp1 <= DETP_W'(cfg.ea_y) * DETP_W'(cfg.eb_x);
    det <= DET_W'(dp0) - DET_W'(dp1);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p_bydx <= PROD_W'(cfg.eb_y) * PROD_W'(dx);
      p_bxdy <= PROD_W'(cfg.eb_x) * PROD_W'(dy);
      p_axdy <= PROD_W'(cfg.ea_x) * PROD_W'(dy);
      p_aydx <= PROD_W'(cfg.ea_y) * PROD_W'(dx);
    end
    if (en.s3) begin
      nu <= NUM_W'(p_bydx) - NUM_W'(p_bxdy);
      nv <= NUM_W'(p_axdy) - NUM_W'(p_aydx);
    end
  end

  assign det_ext = NUM_W'(det);

  always_comb begin
    if (det_ext > 0) begin
      u_ok = (nu >= 0) && (nu < det_ext);
      v_ok = (nv >= 0) && (nv < det_ext);
    end else begin
      u_ok = (nu <= 0) && (nu > det_ext);
      v_ok = (nv <= 0) && (nv > det_ext);
    end
  end

  assign in_rect = (det != '0) && u_ok && v_ok;

endmodule

@@ rtl/core/orfb_blend.sv @@
// Per-channel alpha blend with round half up, divide by 255 via reciprocal.
`timescale 1ns / 1ps

module orfb_blend (
  input  logic                         clk,
  input  orfb_pkg::pipe_en_t           en,
  input  logic [orfb_pkg::COLOR_W-1:0] dst,
  input  logic [orfb_pkg::COLOR_W-1:0] color,
  output logic [orfb_pkg::COLOR_W-1:0] blended
);

  localparam int CW  = orfb_pkg::CHAN_W;
  localparam int NC  = orfb_pkg::NUM_CHAN;
  localparam int BW  = orfb_pkg::BLEND_W;
  localparam int RW  = BW + CW;
  localparam int EW  = BW + 1;
  localparam logic [CW-1:0] CMAX = '1;
  localparam logic [BW-1:0] HALF = BW'(CMAX >> 1);

  logic [CW-1:0] alpha;
  logic [CW-1:0] inv_alpha;
  logic [CW-1:0] src_c [NC];
  logic [BW-1:0] n_next [NC];
  logic [BW-1:0] n [NC];
  logic [BW-1:0] m_next [NC];
  logic [CW-1:0] q0_next [NC];
  logic [RW-1:0] recip [NC];
  logic [BW-1:0] m [NC];
  logic [CW-1:0] q0 [NC];
  logic [EW-1:0] rem [NC];

  assign alpha     = color[orfb_pkg::COLOR_W-1 -: CW];
  assign inv_alpha = CMAX - alpha;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      src_c[c]  = (c == NC - 1) ? alpha : color[c*CW +: CW];
      n_next[c] = BW'(inv_alpha) * BW'(dst[c*CW +: CW]) + BW'(alpha) * BW'(src_c[c]);
      m_next[c] = n[c] + HALF;
      recip[c]  = {m_next[c], {CW{1'b0}}} + RW'(m_next[c]);
      q0_next[c] = recip[c][RW-1 -: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      n <= n_next;
    end
    if (en.s3) begin
      m  <= m_next;
      q0 <= q0_next;
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      rem[c] = EW'(m[c]) - EW'({q0[c], {CW{1'b0}}}) + EW'(q0[c]);
      blended[c*CW +: CW] = (rem[c] >= EW'(CMAX)) ? q0[c] + CW'(1) : q0[c];
    end
  end

endmodule

@@ rtl/core/oriented_rect_fill_blend_top.sv @@
// Pipeline: 4 register stages incl. output.
// One pixel per clock unless stalled; each stage holds its request until the next frees.
// Out of reset, intake stalls only when all four stages are full and m_tready is low.
// Each cross-product multiplier is followed by a register before the compare.
// Reset clears all stage valids, holds s_tready low and loads the default rectangle and colour.
`timescale 1ns / 1ps

module oriented_rect_fill_blend_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [orfb_pkg::IDX_W-1:0]           cfg_index,
  input  logic [orfb_pkg::COLOR_W-1:0]         cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [orfb_pkg::TDATA_IN_W-1:0]      s_tdata,  // pixel_x, pixel_y, dest_pixel
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [orfb_pkg::TDATA_OUT_W-1:0]     m_tdata,  // new_pixel
  output logic                                 m_tuser   // covered
);

  localparam int PB = orfb_pkg::PIX_BITS;
  localparam int CW = orfb_pkg::COLOR_W;

  orfb_pkg::geom_cfg_t  geom_cfg;
  logic [CW-1:0]        fill_color;
  orfb_pkg::pipe_en_t   pen;

  logic          v1, v2, v3, v4;
  logic          en1, en2, en3, en4;
  logic [PB-1:0] px1, py1;
  logic [CW-1:0] dst1, dst2, dst3;
  logic [CW-1:0] new_pixel;
  logic          covered;
  logic          in_rect;
  logic [CW-1:0] blended;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      geom_cfg.ox   <= '0;
      geom_cfg.oy   <= '0;
      geom_cfg.ea_x <= orfb_pkg::CFG_W'(1 << orfb_pkg::FRAC_BITS);
      geom_cfg.ea_y <= '0;
      geom_cfg.eb_x <= '0;
      geom_cfg.eb_y <= orfb_pkg::CFG_W'(1 << orfb_pkg::FRAC_BITS);
      fill_color    <= '1;
    end else if (cfg_we) begin
      case (orfb_pkg::cfg_reg_t'(cfg_index))
        orfb_pkg::REG_ORIGIN_X:   geom_cfg.ox   <= cfg_data[orfb_pkg::CFG_W-1:0];
        orfb_pkg::REG_ORIGIN_Y:   geom_cfg.oy   <= cfg_data[orfb_pkg::CFG_W-1:0];
        orfb_pkg::REG_EDGE_A_X:   geom_cfg.ea_x <= cfg_data[orfb_pkg::CFG_W-1:0];
        orfb_pkg::REG_EDGE_A_Y:   geom_cfg.ea_y <= cfg_data[orfb_pkg::CFG_W-1:0];
        orfb_pkg::REG_EDGE_B_X:   geom_cfg.eb_x <= cfg_data[orfb_pkg::CFG_W-1:0];
        orfb_pkg::REG_EDGE_B_Y:   geom_cfg.eb_y <= cfg_data[orfb_pkg::CFG_W-1:0];
        orfb_pkg::REG_FILL_COLOR: fill_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next one loads
  assign en4 = !v4 || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1 && !rst;
  assign pen.s2 = en2;
  assign pen.s3 = en3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      px1  <= s_tdata[PB-1:0];
      py1  <= s_tdata[2*PB-1:PB];
      dst1 <= s_tdata[2*PB +: CW];
    end
    if (en2) dst2 <= dst1;
    if (en3) dst3 <= dst2;
    if (en4) begin
      new_pixel <= in_rect ? blended : dst3;
      covered   <= in_rect;
    end
  end

  orfb_geom u_geom (
    .clk     (clk),
    .en      (pen),
    .px      (px1),
    .py      (py1),
    .cfg     (geom_cfg),
    .in_rect (in_rect)
  );

  orfb_blend u_blend (
    .clk     (clk),
    .en      (pen),
    .dst     (dst1),
    .color   (fill_color),
    .blended (blended)
  );

  assign m_tvalid = v4;
  assign m_tdata  = orfb_pkg::TDATA_OUT_W'(new_pixel);
  assign m_tuser  = covered;

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted request did not enter first stage");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !v4 |-> s_tready)
    else $error("intake stalled with an empty output register");

  a_drain_to_out: assert property (@(posedge clk) disable iff (rst)
    v3 && !v4 |=> m_tvalid)
    else $error("result did not advance into empty output register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
